[rtl/tpsuv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpsuv_pkg;

    // Default widths of the coordinate and result fields.
    localparam int COORD_BITS_DEF  = 24;
    localparam int RESULT_BITS_DEF = 32;

    // Fraction bits of the Q15.16 results.
    localparam int FRAC_BITS = 16;

    // Configuration registers.
    localparam int DET_THR_BITS  = 63;
    localparam int U_THR_BITS    = 31;
    localparam int CFG_DATA_BITS = 63;
    localparam int CFG_IDX_BITS  = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DET_THRESHOLD = 1'b0,
        REG_U_THRESHOLD   = 1'b1
    } cfg_reg_t;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 8;

endpackage

`default_nettype wire

[rtl/triangle_point_to_strip_uv.sv]
`timescale 1ns / 1ps
`default_nettype none

// Strip coordinates of a query point against a triangle.
//
// Input channel: a transaction is taken at a rising edge where start is high and
// busy is low; the twelve coordinate ports carry the three vertices and the query
// point as signed Q11.12 values. Output channel: done is high for exactly one cycle
// with coord_u, coord_v (signed Q15.16, saturated), degenerate and v_forced valid
// in that cycle. The receiver cannot stall, so the output side never holds back.
// Configuration: a write at any edge where cfg_we is high stores cfg_data in the
// register selected by cfg_index (0 = determinant threshold, 1 = u threshold);
// write only while no transaction is in flight.
// Throughput is one transaction per cycle. A transaction passes through seven
// front stages for the Gram products and determinant, the queue, one operand
// stage, RESULT_BITS + 1 stages of the two parallel bit-per-stage dividers, and
// the result register. busy rises only when the credit count for the queue is
// used up and nothing leaves the queue in that cycle, which never happens since
// the back part drains the queue every cycle.
// Reset clears all valid bits, the queue and the credit count, and sets both
// thresholds to one.
module triangle_point_to_strip_uv
    import tpsuv_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RESULT_BITS = RESULT_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic signed [COORD_BITS-1:0] vertex1_x,
    input  wire logic signed [COORD_BITS-1:0] vertex1_y,
    input  wire logic signed [COORD_BITS-1:0] vertex1_z,
    input  wire logic signed [COORD_BITS-1:0] vertex2_x,
    input  wire logic signed [COORD_BITS-1:0] vertex2_y,
    input  wire logic signed [COORD_BITS-1:0] vertex2_z,
    input  wire logic signed [COORD_BITS-1:0] vertex3_x,
    input  wire logic signed [COORD_BITS-1:0] vertex3_y,
    input  wire logic signed [COORD_BITS-1:0] vertex3_z,
    input  wire logic signed [COORD_BITS-1:0] query_x,
    input  wire logic signed [COORD_BITS-1:0] query_y,
    input  wire logic signed [COORD_BITS-1:0] query_z,
    output logic                              done,
    output logic signed [RESULT_BITS-1:0]     coord_u,
    output logic signed [RESULT_BITS-1:0]     coord_v,
    output logic                              degenerate,
    output logic                              v_forced
);

    // Queue entry: degenerate flag, determinant, second numerator, numerator sum.
    localparam int FW = 2 * (4 * COORD_BITS + 9) + (4 * COORD_BITS + 10) + 1;

    logic [DET_THR_BITS-1:0] det_thr_reg;
    logic [U_THR_BITS-1:0]   u_thr_reg;

    logic          push;
    logic [FW-1:0] push_data;
    logic          pop;
    logic [FW-1:0] rdata;
    logic          empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_thr_reg <= DET_THR_BITS'(1);
            u_thr_reg   <= U_THR_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DET_THRESHOLD: det_thr_reg <= cfg_data[DET_THR_BITS-1:0];
                REG_U_THRESHOLD:   u_thr_reg   <= cfg_data[U_THR_BITS-1:0];
                default:           det_thr_reg <= det_thr_reg;
            endcase
        end
    end

    tpsuv_front #(.COORD_BITS(COORD_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .pop       (pop),
        .det_thr   (det_thr_reg),
        .vertex1_x (vertex1_x),
        .vertex1_y (vertex1_y),
        .vertex1_z (vertex1_z),
        .vertex2_x (vertex2_x),
        .vertex2_y (vertex2_y),
        .vertex2_z (vertex2_z),
        .vertex3_x (vertex3_x),
        .vertex3_y (vertex3_y),
        .vertex3_z (vertex3_z),
        .query_x   (query_x),
        .query_y   (query_y),
        .query_z   (query_z),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    tpsuv_fifo #(.WIDTH(FW), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .pop   (pop),
        .rdata (rdata),
        .empty (empty)
    );

    tpsuv_back #(.COORD_BITS(COORD_BITS), .RESULT_BITS(RESULT_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .rdata      (rdata),
        .u_thr      (u_thr_reg),
        .pop        (pop),
        .done       (done),
        .coord_u    (coord_u),
        .coord_v    (coord_v),
        .degenerate (degenerate),
        .v_forced   (v_forced)
    );

endmodule

`default_nettype wire

[rtl/tpsuv_wmul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-stage signed multiplier built from four half-width partial products.
module tpsuv_wmul
#(
    parameter int W = 52
)
(
    input  wire logic                  clk,
    input  wire logic signed [W-1:0]   a,
    input  wire logic signed [W-1:0]   b,
    output logic signed [2*W-1:0]      p
);

    localparam int L = W / 2;
    localparam int H = W - L;
    localparam int PW = 2 * W;

    logic        [L-1:0]     al;
    logic        [L-1:0]     bl;
    logic signed [H-1:0]     ah;
    logic signed [H-1:0]     bh;

    logic signed [2*H-1:0]   hh_reg;
    logic signed [H+L:0]     hl_reg;
    logic signed [H+L:0]     lh_reg;
    logic        [2*L-1:0]   ll_reg;
    logic signed [PW-1:0]    p_reg;

    assign al = a[L-1:0];
    assign bl = b[L-1:0];
    assign ah = a[W-1:L];
    assign bh = b[W-1:L];

    always_ff @(posedge clk)
    begin
        hh_reg <= ah * bh;
        hl_reg <= ah * signed'({1'b0, bl});
        lh_reg <= bh * signed'({1'b0, al});
        ll_reg <= al * bl;
        p_reg  <= (PW'(hh_reg) <<< (2 * L))
                + ((PW'(hl_reg) + PW'(lh_reg)) <<< L)
                + signed'(PW'(ll_reg));
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[rtl/tpsuv_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Front part: edge vectors, Gram products, determinant and numerators.
module tpsuv_front
    import tpsuv_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         pop,
    input  wire logic [DET_THR_BITS-1:0]      det_thr,
    input  wire logic signed [COORD_BITS-1:0] vertex1_x,
    input  wire logic signed [COORD_BITS-1:0] vertex1_y,
    input  wire logic signed [COORD_BITS-1:0] vertex1_z,
    input  wire logic signed [COORD_BITS-1:0] vertex2_x,
    input  wire logic signed [COORD_BITS-1:0] vertex2_y,
    input  wire logic signed [COORD_BITS-1:0] vertex2_z,
    input  wire logic signed [COORD_BITS-1:0] vertex3_x,
    input  wire logic signed [COORD_BITS-1:0] vertex3_y,
    input  wire logic signed [COORD_BITS-1:0] vertex3_z,
    input  wire logic signed [COORD_BITS-1:0] query_x,
    input  wire logic signed [COORD_BITS-1:0] query_y,
    input  wire logic signed [COORD_BITS-1:0] query_z,
    output logic                              busy,
    output logic                              push,
    output logic [2*(4*COORD_BITS+9)+(4*COORD_BITS+10):0] push_data
);

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int GW   = PW + 2;
    localparam int XW   = 2 * GW;
    localparam int NW   = XW + 1;
    localparam int SW   = NW + 1;
    localparam int TW   = ((NW > DET_THR_BITS) ? NW : DET_THR_BITS) + 1;
    localparam int NSTG = 7;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic signed [COORD_BITS-1:0] p1 [3];
    logic signed [COORD_BITS-1:0] p2 [3];
    logic signed [COORD_BITS-1:0] p3 [3];
    logic signed [COORD_BITS-1:0] pq [3];

    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [DW-1:0] dq_reg [3];
    logic signed [DW-1:0] opa [5][3];
    logic signed [DW-1:0] opb [5][3];
    logic signed [PW-1:0] prod_reg [5][3];
    logic signed [GW-1:0] dot_reg [5];
    logic signed [XW-1:0] xp [6];
    logic signed [NW-1:0] det_reg;
    logic signed [NW-1:0] n1_reg;
    logic signed [NW-1:0] n2_reg;
    logic signed [NW-1:0] det2_reg;
    logic signed [NW-1:0] n2b_reg;
    logic signed [SW-1:0] s_reg;
    logic                 degen_reg;
    logic signed [TW-1:0] det_ext;
    logic signed [TW-1:0] thr_ext;

    logic [NSTG-1:0] vld_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            accept;

    assign p1[0] = vertex1_x;
    assign p1[1] = vertex1_y;
    assign p1[2] = vertex1_z;
    assign p2[0] = vertex2_x;
    assign p2[1] = vertex2_y;
    assign p2[2] = vertex2_z;
    assign p3[0] = vertex3_x;
    assign p3[1] = vertex3_y;
    assign p3[2] = vertex3_z;
    assign pq[0] = query_x;
    assign pq[1] = query_y;
    assign pq[2] = query_z;

    // A credit freed by a pop in the same cycle can be reused at once.
    assign accept = start && !busy;
    assign busy   = (cnt_reg == CNTW'(QUEUE_DEPTH)) && !pop;

    // Credit count: items in the front pipeline plus items in the queue.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!accept && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vld_reg <= {vld_reg[NSTG-2:0], accept};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            opa[0][k] = e1_reg[k];
            opb[0][k] = e1_reg[k];
            opa[1][k] = e1_reg[k];
            opb[1][k] = e2_reg[k];
            opa[2][k] = e2_reg[k];
            opb[2][k] = e2_reg[k];
            opa[3][k] = dq_reg[k];
            opb[3][k] = e1_reg[k];
            opa[4][k] = dq_reg[k];
            opb[4][k] = e2_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_reg[k] <= DW'(p2[k]) - DW'(p1[k]);
            e2_reg[k] <= DW'(p3[k]) - DW'(p1[k]);
            dq_reg[k] <= DW'(pq[k]) - DW'(p1[k]);
        end
        for (int j = 0; j < 5; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[j][k] <= opa[j][k] * opb[j][k];
            end
            dot_reg[j] <= GW'(prod_reg[j][0]) + GW'(prod_reg[j][1]) + GW'(prod_reg[j][2]);
        end
    end

    // dot_reg: 0 = d11, 1 = d12, 2 = d22, 3 = t1, 4 = t2.
    tpsuv_wmul #(.W(GW)) u_mul_d11d22 (.clk(clk), .a(dot_reg[0]), .b(dot_reg[2]), .p(xp[0]));
    tpsuv_wmul #(.W(GW)) u_mul_d12d12 (.clk(clk), .a(dot_reg[1]), .b(dot_reg[1]), .p(xp[1]));
    tpsuv_wmul #(.W(GW)) u_mul_t1d22  (.clk(clk), .a(dot_reg[3]), .b(dot_reg[2]), .p(xp[2]));
    tpsuv_wmul #(.W(GW)) u_mul_t2d12  (.clk(clk), .a(dot_reg[4]), .b(dot_reg[1]), .p(xp[3]));
    tpsuv_wmul #(.W(GW)) u_mul_t2d11  (.clk(clk), .a(dot_reg[4]), .b(dot_reg[0]), .p(xp[4]));
    tpsuv_wmul #(.W(GW)) u_mul_t1d12  (.clk(clk), .a(dot_reg[3]), .b(dot_reg[1]), .p(xp[5]));

    assign det_ext = TW'(det_reg);
    assign thr_ext = signed'(TW'(det_thr));

    always_ff @(posedge clk)
    begin
        det_reg   <= NW'(xp[0]) - NW'(xp[1]);
        n1_reg    <= NW'(xp[2]) - NW'(xp[3]);
        n2_reg    <= NW'(xp[4]) - NW'(xp[5]);
        s_reg     <= SW'(n1_reg) + SW'(n2_reg);
        det2_reg  <= det_reg;
        n2b_reg   <= n2_reg;
        degen_reg <= (det_ext <= thr_ext) && (det_ext >= -thr_ext);
    end

    assign push      = vld_reg[NSTG-1];
    assign push_data = {degen_reg, det2_reg, n2b_reg, s_reg};

endmodule

`default_nettype wire

[rtl/tpsuv_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Small first-in first-out queue; the writer never overfills it.
module tpsuv_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rptr_reg];
    assign empty = (cnt_reg == '0);

endmodule

`default_nettype wire

[rtl/tpsuv_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, saturating magnitude.
// The quotient has QB = RB - 1 bits.
module tpsuv_div
#(
    parameter int AW = 122,
    parameter int BW = 105,
    parameter int RB = 32
)
(
    input  wire logic          clk,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    input  wire logic          neg,
    output logic [RB-1:0]      mag,
    output logic               mag_neg
);

    localparam int QB = RB - 1;
    localparam int W  = ((AW > BW + QB) ? AW : BW + QB) + 1;

    logic [W-1:0]  rem_reg [QB+1];
    logic [BW-1:0] b_reg   [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          big_reg [QB+1];
    logic          neg_reg [QB+1];
    logic [RB-1:0] mag_reg;
    logic          mag_neg_reg;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= W'(a);
        b_reg[0]   <= b;
        q_reg[0]   <= '0;
        big_reg[0] <= (W'(a) >= (W'(b) << QB));
        neg_reg[0] <= neg;
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_stage
        localparam int K = QB - i;
        logic [W-1:0] sub;
        logic         take;

        assign sub  = W'(b_reg[i-1]) << K;
        assign take = (rem_reg[i-1] >= sub);

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= take ? rem_reg[i-1] - sub : rem_reg[i-1];
            q_reg[i]   <= q_reg[i-1] | (take ? (QB'(1) << K) : '0);
            b_reg[i]   <= b_reg[i-1];
            big_reg[i] <= big_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
        end
    end

    // A negative result may reach one more than the positive limit.
    always_ff @(posedge clk)
    begin
        if (big_reg[QB])
        begin
            mag_reg <= neg_reg[QB] ? (RB'(1) << QB) : ((RB'(1) << QB) - 1'b1);
        end
        else
        begin
            mag_reg <= RB'(q_reg[QB]);
        end
        mag_neg_reg <= neg_reg[QB];
    end

    assign mag     = mag_reg;
    assign mag_neg = mag_neg_reg;

endmodule

`default_nettype wire

[rtl/tpsuv_back.sv]
`timescale 1ns / 1ps
`default_nettype none

// Back part: the two divisions, the small-u test and the result register.
module tpsuv_back
    import tpsuv_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RESULT_BITS = RESULT_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        empty,
    input  wire logic [2*(4*COORD_BITS+9)+(4*COORD_BITS+10):0] rdata,
    input  wire logic [U_THR_BITS-1:0]       u_thr,
    output logic                             pop,
    output logic                             done,
    output logic signed [RESULT_BITS-1:0]    coord_u,
    output logic signed [RESULT_BITS-1:0]    coord_v,
    output logic                             degenerate,
    output logic                             v_forced
);

    localparam int DW  = COORD_BITS + 1;
    localparam int GW  = 2 * DW + 2;
    localparam int NW  = 2 * GW + 1;
    localparam int SW  = NW + 1;
    localparam int FW  = 1 + NW + NW + SW;
    localparam int LAT = RESULT_BITS + 1;
    localparam int CMW = RESULT_BITS + U_THR_BITS;

    logic signed [NW-1:0] det_in;
    logic signed [NW-1:0] n2_in;
    logic signed [SW-1:0] s_in;
    logic [NW-1:0]        det_abs;
    logic [NW-1:0]        n2_abs;
    logic [SW-1:0]        s_abs;

    logic [SW+FRAC_BITS-1:0] ua_reg;
    logic [NW-1:0]           ub_reg;
    logic [NW+FRAC_BITS-1:0] va_reg;
    logic [SW-1:0]           vb_reg;
    logic                    uneg_reg;
    logic                    vneg_reg;
    logic                    pvld_reg;
    logic                    pdeg_reg;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] deg_reg;

    logic [RESULT_BITS-1:0] u_mag;
    logic [RESULT_BITS-1:0] v_mag;
    logic                   u_neg;
    logic                   v_neg;
    logic                   small_u;
    logic                   deg_out;

    logic                          done_reg;
    logic signed [RESULT_BITS-1:0] coord_u_reg;
    logic signed [RESULT_BITS-1:0] coord_v_reg;
    logic                          degenerate_reg;
    logic                          v_forced_reg;

    // The division pipeline never stalls, so the queue drains every cycle.
    assign pop = !empty;

    assign det_in = rdata[FW-2 -: NW];
    assign n2_in  = rdata[SW+NW-1 -: NW];
    assign s_in   = rdata[SW-1:0];

    assign det_abs = det_in[NW-1] ? unsigned'(-det_in) : unsigned'(det_in);
    assign n2_abs  = n2_in[NW-1] ? unsigned'(-n2_in) : unsigned'(n2_in);
    assign s_abs   = s_in[SW-1] ? unsigned'(-s_in) : unsigned'(s_in);

    always_ff @(posedge clk)
    begin
        ua_reg   <= {s_abs, FRAC_BITS'(0)};
        ub_reg   <= det_abs;
        va_reg   <= {n2_abs, FRAC_BITS'(0)};
        vb_reg   <= s_abs;
        uneg_reg <= s_in[SW-1] ^ det_in[NW-1];
        vneg_reg <= n2_in[NW-1] ^ s_in[SW-1];
        pdeg_reg <= rdata[FW-1];
    end

    tpsuv_div #(.AW(SW + FRAC_BITS), .BW(NW), .RB(RESULT_BITS)) u_div_u
    (
        .clk     (clk),
        .a       (ua_reg),
        .b       (ub_reg),
        .neg     (uneg_reg),
        .mag     (u_mag),
        .mag_neg (u_neg)
    );

    tpsuv_div #(.AW(NW + FRAC_BITS), .BW(SW), .RB(RESULT_BITS)) u_div_v
    (
        .clk     (clk),
        .a       (va_reg),
        .b       (vb_reg),
        .neg     (vneg_reg),
        .mag     (v_mag),
        .mag_neg (v_neg)
    );

    always_ff @(posedge clk)
    begin
        deg_reg <= {deg_reg[LAT-2:0], pdeg_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= pop;
            vld_reg  <= {vld_reg[LAT-2:0], pvld_reg};
            done_reg <= vld_reg[LAT-1];
        end
    end

    assign deg_out = deg_reg[LAT-1];
    assign small_u = (CMW'(u_mag) <= CMW'(u_thr));

    always_ff @(posedge clk)
    begin
        degenerate_reg <= deg_out;
        v_forced_reg   <= !deg_out && small_u;
        if (deg_out)
        begin
            coord_u_reg <= '0;
        end
        else
        begin
            coord_u_reg <= u_neg ? -signed'(u_mag) : signed'(u_mag);
        end
        if (deg_out || small_u)
        begin
            coord_v_reg <= '0;
        end
        else
        begin
            coord_v_reg <= v_neg ? -signed'(v_mag) : signed'(v_mag);
        end
    end

    assign done       = done_reg;
    assign coord_u    = coord_u_reg;
    assign coord_v    = coord_v_reg;
    assign degenerate = degenerate_reg;
    assign v_forced   = v_forced_reg;

endmodule

`default_nettype wire
